// ----- design/indexed_insert_delete_list_macros.svh -----
// Assertion helpers for the list RTL.
`ifndef INDEXED_INSERT_DELETE_LIST_MACROS_SVH
`define INDEXED_INSERT_DELETE_LIST_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define IIDL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication: antecedent on this edge, consequent on the next edge.
`define IIDL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/iidl_pkg.sv -----
`default_nettype none

package iidl_pkg;

   localparam int DEPTH = 16;

   localparam int VAL_W   = 32;
   localparam int MODE_W  = 3;
   localparam int POS_W   = 5;
   localparam int ST_W    = 2;
   localparam int OUT_CNT_W = 5;

   // cell index and entry count (count may equal DEPTH)
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   // common width for position vs count compares
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_DATA_W = 40;  // 3 + 5 + 32
   localparam int RSP_DATA_W = 40;  // 32 + 2 + 5, padded

   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   // broadcast to every cell for one request
   typedef struct packed {
      logic                    shift_up;    // insert / append: load at index, move up above
      logic                    shift_down;  // erase: pull from right at and above index
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
   } iidl_op_type;

endpackage

`default_nettype wire

// ----- design/iidl_cell.sv -----
`default_nettype none

module iidl_cell (
   input  wire                                clock,
   input  wire  iidl_pkg::iidl_op_type        op,
   input  wire  [iidl_pkg::IDX_W-1:0]         my_index,
   input  wire  signed [iidl_pkg::VAL_W-1:0]  left_value,
   input  wire  signed [iidl_pkg::VAL_W-1:0]  right_value,
   output logic signed [iidl_pkg::VAL_W-1:0]  value
);
   import iidl_pkg::*;

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (op.shift_up) begin
         if (my_index == op.index) begin
            value_in = op.value;
         end else if (my_index > op.index) begin
            value_in = left_value;
         end
      end else if (op.shift_down) begin
         if (my_index >= op.index) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// ----- design/indexed_insert_delete_list.sv -----
// Indexed insert/delete list: up to DEPTH signed 32-bit entries held in a
// row of cells, each cell holding, loading or taking a neighbor's value.
//
// req channel: one request per transfer, modes append, insert at index,
//   erase at index, remove last, read at index, clear.
// rsp channel: exactly one response per request, in order, carrying the
//   read value (zero unless a successful read), a status code and the entry
//   count after the request.
//
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while the rsp side is not stalled; every
//   cell updates in the same cycle, so insert and erase cost no more than
//   append. The response register is the only pipeline stage.
// Back pressure: req_tready is high while the response register is empty or
//   being drained; a stalled rsp side holds its response and blocks new
//   requests until it is taken.
// Reset: clears the entry count and response valid; cell contents are not
//   reset and are only ever read after being written.
`default_nettype none

module indexed_insert_delete_list (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [2:0] mode, [7:3] position, [39:8] item_value
   input  wire  [iidl_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [31:0] read_value, [33:32] status, [38:34] entry_count, [39] zero
   output logic [iidl_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import iidl_pkg::*;
   `include "indexed_insert_delete_list_macros.svh"

   // request fields
   logic [MODE_W-1:0]       req_mode;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_item_value;

   assign req_mode       = req_tdata[2:0];
   assign req_position   = req_tdata[7:3];
   assign req_item_value = req_tdata[39:8];

   // list state
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // response register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic signed [VAL_W-1:0] rsp_value_in;
   logic [ST_W-1:0]         rsp_status_ff;
   logic [ST_W-1:0]         rsp_status_in;
   logic [OUT_CNT_W-1:0]    rsp_count_ff;

   logic req_fire;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // cell row
   logic signed [VAL_W-1:0] cell_value [DEPTH];
   iidl_op_type             cell_op;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             is_empty;
   logic             is_full;
   logic [IDX_W-1:0] rd_index;

   assign pos_ext  = CMP_W'(req_position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   // only used once position is checked against count (below it, or equal for insert)
   assign rd_index = IDX_W'(req_position);

   // request decode: status, next count and the op sent to the cells
   always_comb begin
      count_in         = count_ff;
      rsp_value_in     = '0;
      rsp_status_in    = ST_OK;
      cell_op          = '0;
      cell_op.value    = req_item_value;
      cell_op.index    = rd_index;
      if (req_fire) begin
         unique case (req_mode)
            MODE_APPEND: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cell_op.shift_up = 1'b1;
                  cell_op.index    = IDX_W'(count_ff);
                  count_in         = count_ff + CNT_W'(1);
               end
            end
            MODE_INSERT: begin
               // range check ranks ahead of the full check
               if (pos_ext > cnt_ext) begin
                  rsp_status_in = ST_RANGE;
               end else if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cell_op.shift_up = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end
            MODE_ERASE: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (pos_ext >= cnt_ext) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  cell_op.shift_down = 1'b1;
                  count_in           = count_ff - CNT_W'(1);
               end
            end
            MODE_POP: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            MODE_READ: begin
               if (pos_ext >= cnt_ext) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  rsp_value_in = cell_value[rd_index];
               end
            end
            MODE_CLEAR: begin
               count_in = '0;
            end
            default: begin
               // unused modes: no change, status ok
            end
         endcase
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= OUT_CNT_W'(count_in);
      end
   end

   // the cell row; ends see the op value on the left and themselves on the right
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = cell_op.value;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_value[i];
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      iidl_cell u_cell (
         .clock       (clock),
         .op          (cell_op),
         .my_index    (IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_status_ff, rsp_value_ff};

   // a full status only ever comes back with the list at capacity
   logic full_rsp_ok;
   assign full_rsp_ok = !(rsp_valid_ff && rsp_status_ff == ST_FULL) ||
                        (rsp_count_ff == OUT_CNT_W'(DEPTH));

   `IIDL_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count past capacity")
   `IIDL_ASSERT_NEXT(a_rsp_follows, req_fire, rsp_valid_ff, "request without response")
   `IIDL_ASSERT_NEXT(a_count_idle, !req_fire, $stable(count_ff), "count moved without request")
   `IIDL_ASSERT(a_full_count, full_rsp_ok, "full status below capacity")

endmodule

`default_nettype wire
